>>> rtl/mctp_ce_pkg.sv
package mctp_ce_pkg;

  localparam int unsigned PcW = 6;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  // byte source selected by one control word
  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_REQ_ADDR,
    SRC_COUNT,
    SRC_OWN_ADDR,
    SRC_REQ_EID,
    SRC_EID,
    SRC_TAG,
    SRC_INST,
    SRC_CMD,
    SRC_PEC
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [7:0] konst;
    logic       first;
    logic       last;
    logic       dispatch;
  } ucode_t;

  localparam logic [7:0] SmbusCmdMctp = 8'h0f;
  localparam logic [7:0] HdrVersion   = 8'h01;
  localparam logic [7:0] TagFlags     = 8'hc0;

  localparam logic [7:0] CmdSetEid   = 8'd1;
  localparam logic [7:0] CmdGetEid   = 8'd2;
  localparam logic [7:0] CmdGetUuid  = 8'd3;
  localparam logic [7:0] CmdVersion  = 8'd4;
  localparam logic [7:0] CmdMsgTypes = 8'd5;
  localparam logic [7:0] CmdVdm      = 8'd6;

  localparam logic [PcW-1:0] EntrySetEid   = 6'd11;
  localparam logic [PcW-1:0] EntryGetEid   = 6'd16;
  localparam logic [PcW-1:0] EntryGetUuid  = 6'd21;
  localparam logic [PcW-1:0] EntryVersion  = 6'd39;
  localparam logic [PcW-1:0] EntryMsgTypes = 6'd46;
  localparam logic [PcW-1:0] EntryVdm      = 6'd51;

  function automatic logic cmd_known(input logic [7:0] cmd);
    return (cmd >= CmdSetEid) && (cmd <= CmdVdm);
  endfunction

  function automatic logic [PcW-1:0] cmd_entry(input logic [7:0] cmd);
    logic [PcW-1:0] e;
    unique case (cmd)
      CmdSetEid:   e = EntrySetEid;
      CmdGetEid:   e = EntryGetEid;
      CmdGetUuid:  e = EntryGetUuid;
      CmdVersion:  e = EntryVersion;
      CmdMsgTypes: e = EntryMsgTypes;
      default:     e = EntryVdm;
    endcase
    return e;
  endfunction

  // smbus byte count: 8 header bytes plus payload
  function automatic logic [7:0] reply_count(input logic [7:0] cmd);
    logic [7:0] n;
    unique case (cmd)
      CmdGetUuid: n = 8'd25;
      CmdVersion: n = 8'd14;
      CmdVdm:     n = 8'd15;
      default:    n = 8'd12;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ 8'h07) : (v << 1);
    end
    return v;
  endfunction

  function automatic ucode_t uw(input src_e src, input logic [7:0] k);
    ucode_t w;
    w.src      = src;
    w.konst    = k;
    w.first    = 1'b0;
    w.last     = 1'b0;
    w.dispatch = 1'b0;
    return w;
  endfunction

  function automatic ucode_t uc(input logic [7:0] k);
    return uw(SRC_CONST, k);
  endfunction

  function automatic ucode_t upec();
    ucode_t w;
    w      = uw(SRC_PEC, 8'h00);
    w.last = 1'b1;
    return w;
  endfunction

  // reply program: common header, then one segment per command ending in the pec
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      6'd0: begin
        w       = uw(SRC_REQ_ADDR, 8'h00);
        w.first = 1'b1;
      end
      6'd1:  w = uc(SmbusCmdMctp);
      6'd2:  w = uw(SRC_COUNT, 8'h00);
      6'd3:  w = uw(SRC_OWN_ADDR, 8'h00);
      6'd4:  w = uc(HdrVersion);
      6'd5:  w = uw(SRC_REQ_EID, 8'h00);
      6'd6:  w = uw(SRC_EID, 8'h00);
      6'd7:  w = uw(SRC_TAG, 8'h00);
      6'd8:  w = uc(8'h00);
      6'd9:  w = uw(SRC_INST, 8'h00);
      6'd10: begin
        w          = uw(SRC_CMD, 8'h00);
        w.dispatch = 1'b1;
      end
      // set eid
      6'd11: w = uc(8'h00);
      6'd12: w = uc(8'h00);
      6'd13: w = uw(SRC_EID, 8'h00);
      6'd14: w = uc(8'h00);
      6'd15: w = upec();
      // get eid
      6'd16: w = uc(8'h00);
      6'd17: w = uw(SRC_EID, 8'h00);
      6'd18: w = uc(8'h00);
      6'd19: w = uc(8'h00);
      6'd20: w = upec();
      // get uuid
      6'd21: w = uc(8'h00);
      6'd22: w = uc(8'hdf);
      6'd23: w = uc(8'h2b);
      6'd24: w = uc(8'hbe);
      6'd25: w = uc(8'hba);
      6'd26: w = uc(8'h73);
      6'd27: w = uc(8'hc6);
      6'd28: w = uc(8'h4e);
      6'd29: w = uc(8'h33);
      6'd30: w = uc(8'h82);
      6'd31: w = uc(8'h5c);
      6'd32: w = uc(8'h98);
      6'd33: w = uc(8'h00);
      6'd34: w = uc(8'h15);
      6'd35: w = uc(8'h8a);
      6'd36: w = uc(8'hc9);
      6'd37: w = uc(8'h2e);
      6'd38: w = upec();
      // version support
      6'd39: w = uc(8'h00);
      6'd40: w = uc(8'h01);
      6'd41: w = uc(8'h00);
      6'd42: w = uc(8'h00);
      6'd43: w = uc(8'h03);
      6'd44: w = uc(8'h01);
      6'd45: w = upec();
      // message type support
      6'd46: w = uc(8'h00);
      6'd47: w = uc(8'h02);
      6'd48: w = uc(8'h00);
      6'd49: w = uc(8'h07);
      6'd50: w = upec();
      // vendor defined message support
      6'd51: w = uc(8'h00);
      6'd52: w = uc(8'hff);
      6'd53: w = uc(8'h00);
      6'd54: w = uc(8'h19);
      6'd55: w = uc(8'he5);
      6'd56: w = uc(8'h00);
      6'd57: w = uc(8'h00);
      6'd58: w = upec();
      default: w = upec();
    endcase
    return w;
  endfunction

endpackage

>>> rtl/mctp_smbus_control_endpoint_top.sv
// channel   direction  handshake                  payload
// in        sink       in_valid_i / in_stall_o    kind_i, data_byte_i
// out       source     out_valid_o / out_stall_i  tx_byte_o, is_address_o, last_o
// cfg       sink       cfg_we_i                   cfg_wdata_i (own slave address)
//
// start, byte and finish events are taken while in_stall_o is low; a finish that
// answers starts a reply run of 16 to 29 beats read from the control rom, one
// beat per cycle while out_stall_i is low. in_stall_o is high while the rom
// program runs; the last beat may still sit in the output register when the
// next event is taken.
// reset clears the step counter, the output valid and all captured fields.
module mctp_smbus_control_endpoint_top
  import mctp_ce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       is_address_o,
  output logic       last_o
);

  logic [6:0]     own_addr_q;
  logic [7:0]     pos_q;
  logic [6:0]     req_addr_q;
  logic [7:0]     req_eid_q;
  logic [2:0]     tag_q;
  logic [7:0]     msg_kind_q;
  logic [4:0]     inst_q;
  logic [7:0]     cmd_q;
  logic [7:0]     eid_q;

  logic           run_q, run_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic [7:0]     crc_q, crc_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     tx_byte_q, tx_byte_d;
  logic           is_addr_q, is_addr_d;
  logic           last_q, last_d;

  logic           in_fire;
  logic           step;
  ucode_t         uword;
  logic [7:0]     beat_byte;

  assign in_stall_o = run_q;
  assign in_fire    = in_valid_i && !run_q;
  assign step       = run_q && (!out_valid_q || !out_stall_i);
  assign uword      = ucode_rom(pc_q);

  always_comb begin
    unique case (uword.src)
      SRC_CONST:    beat_byte = uword.konst;
      SRC_REQ_ADDR: beat_byte = {req_addr_q, 1'b0};
      SRC_COUNT:    beat_byte = reply_count(cmd_q);
      SRC_OWN_ADDR: beat_byte = {own_addr_q, 1'b1};
      SRC_REQ_EID:  beat_byte = req_eid_q;
      SRC_EID:      beat_byte = eid_q;
      SRC_TAG:      beat_byte = TagFlags | {5'd0, tag_q};
      SRC_INST:     beat_byte = {3'd0, inst_q};
      SRC_CMD:      beat_byte = cmd_q;
      SRC_PEC:      beat_byte = crc_q;
      default:      beat_byte = 8'h00;
    endcase
  end

  // sequencer and output register
  always_comb begin
    run_d       = run_q;
    pc_d        = pc_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    tx_byte_d   = tx_byte_q;
    is_addr_d   = is_addr_q;
    last_d      = last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
      tx_byte_d   = beat_byte;
      is_addr_d   = uword.first;
      last_d      = uword.last;
      crc_d       = crc8_update(crc_q, beat_byte);
      pc_d        = uword.dispatch ? cmd_entry(cmd_q) : pc_q + 1'b1;
      if (uword.last) begin
        run_d = 1'b0;
      end
    end else if (in_fire && kind_e'(kind_i) == KIND_FINISH &&
                 msg_kind_q == 8'h00 && cmd_known(cmd_q)) begin
      run_d = 1'b1;
      pc_d  = '0;
      crc_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      pc_q        <= '0;
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      pc_q        <= pc_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_byte_q <= tx_byte_d;
    is_addr_q <= is_addr_d;
    last_q    <= last_d;
  end

  // request capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      pos_q      <= '0;
      req_addr_q <= '0;
      req_eid_q  <= '0;
      tag_q      <= '0;
      msg_kind_q <= '0;
      inst_q     <= '0;
      cmd_q      <= '0;
      eid_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        unique case (kind_e'(kind_i))
          KIND_START, KIND_FINISH: begin
            pos_q <= '0;
          end
          KIND_BYTE: begin
            unique case (pos_q)
              8'd2:    req_addr_q <= data_byte_i[7:1];
              8'd5:    req_eid_q  <= data_byte_i;
              8'd6:    tag_q      <= data_byte_i[2:0];
              8'd7:    msg_kind_q <= data_byte_i;
              8'd8:    if (msg_kind_q == 8'h00) inst_q <= data_byte_i[4:0];
              8'd9:    if (msg_kind_q == 8'h00) cmd_q <= data_byte_i;
              8'd11: begin
                if (msg_kind_q == 8'h00 && cmd_q == CmdSetEid) begin
                  eid_q <= data_byte_i;
                end
              end
              default: ;
            endcase
            if (pos_q != 8'hff) begin
              pos_q <= pos_q + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign is_address_o = is_addr_q;
  assign last_o       = last_q;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
  import mctp_ce_pkg::*;
();

  localparam logic [1:0] KindUnused     = 2'd3;
  localparam logic [7:0] MsgTypeControl = 8'h00;
  localparam logic [7:0] CcSuccess      = 8'h00;
  localparam int         ScriptLen      = 29;
  localparam int         IdleLimit      = 4000;
  localparam int         LongHold       = 300;
  localparam int         SettleCycles   = 4;

  localparam logic [7:0] UuidBytes [16] = '{
    8'hdf, 8'h2b, 8'hbe, 8'hba, 8'h73, 8'hc6, 8'h4e, 8'h33,
    8'h82, 8'h5c, 8'h98, 8'h00, 8'h15, 8'h8a, 8'hc9, 8'h2e
  };

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    int         beats;
  } row_t;

  // directed script: reset state, ignored kind, set eid with all-ones fields,
  // a replay, then get uuid with all-zero fields
  localparam row_t Script [ScriptLen] = '{
    '{KIND_FINISH, 8'h00, 0},
    '{KindUnused,  8'ha5, 0},
    '{KIND_START,  8'h00, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h0f, 0},
    '{KIND_BYTE,   8'hff, 0},
    '{KIND_BYTE,   8'h0b, 0},
    '{KIND_BYTE,   8'h01, 0},
    '{KIND_BYTE,   8'hff, 0},
    '{KIND_BYTE,   8'hff, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'hff, 0},
    '{KIND_BYTE,   8'h01, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'hff, 0},
    '{KIND_FINISH, 8'hff, 16},
    '{KIND_FINISH, 8'h00, 16},
    '{KIND_START,  8'hff, 0},
    '{KIND_BYTE,   8'h20, 0},
    '{KIND_BYTE,   8'h0f, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h01, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h00, 0},
    '{KIND_BYTE,   8'h03, 0},
    '{KIND_FINISH, 8'h00, 29}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [6:0] cfg_wdata_i = 7'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i      = 2'd0;
  logic [7:0] data_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] tx_byte_o;
  logic       is_address_o;
  logic       last_o;

  mctp_smbus_control_endpoint_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .tx_byte_o,
    .is_address_o,
    .last_o
  );

  always #6 clk_i = ~clk_i;

  // responder state as the testbench sees it
  logic [6:0] own_addr = '0;
  logic [7:0] rq_pos   = '0;
  logic [6:0] rq_addr  = '0;
  logic [7:0] rq_eid   = '0;
  logic [2:0] rq_tag   = '0;
  logic [7:0] rq_type  = '0;
  logic [4:0] rq_inst  = '0;
  logic [7:0] rq_cmd   = '0;
  logic [7:0] ep_eid   = '0;

  beat_t reply_q [$];
  int    row_beat_q [$];

  int mismatches   = 0;
  int items_sent   = 0;
  int events_seen  = 0;
  int beats_seen   = 0;
  int replies_seen = 0;
  int idle_cycles  = 0;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;

  function automatic logic [7:0] pec_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? 8'h07 : 8'h00);
    return r;
  endfunction

  // applies one bus event and queues the reply beats it causes
  function automatic int respond_to_event(input logic [1:0] k, input logic [7:0] d);
    logic [7:0] frame [$];
    logic [7:0] pay [$];
    logic [7:0] pec;
    beat_t      bt;
    int         i;
    int         n;
    case (k)
      KIND_START: begin
        rq_pos = '0;
        return 0;
      end
      KIND_BYTE: begin
        case (rq_pos)
          8'd2: rq_addr = d[7:1];
          8'd5: rq_eid  = d;
          8'd6: rq_tag  = d[2:0];
          8'd7: rq_type = d;
          default: ;
        endcase
        if (rq_pos > 8'd7 && rq_type == MsgTypeControl) begin
          if (rq_pos == 8'd8) rq_inst = d[4:0];
          else if (rq_pos == 8'd9) rq_cmd = d;
          else if (rq_pos == 8'd11 && rq_cmd == CmdSetEid) ep_eid = d;
        end
        if (rq_pos != 8'hff) rq_pos = rq_pos + 8'd1;
        return 0;
      end
      KIND_FINISH: begin
        rq_pos = '0;
        if (rq_type != MsgTypeControl) return 0;
        pay.push_back(CcSuccess);
        case (rq_cmd)
          CmdSetEid: begin
            pay.push_back(8'h00);
            pay.push_back(ep_eid);
            pay.push_back(8'h00);
          end
          CmdGetEid: begin
            pay.push_back(ep_eid);
            pay.push_back(8'h00);
            pay.push_back(8'h00);
          end
          CmdGetUuid: begin
            foreach (UuidBytes[j]) pay.push_back(UuidBytes[j]);
          end
          CmdVersion: begin
            pay.push_back(8'h01);
            pay.push_back(8'h00);
            pay.push_back(8'h00);
            pay.push_back(8'h03);
            pay.push_back(8'h01);
          end
          CmdMsgTypes: begin
            pay.push_back(8'h02);
            pay.push_back(8'h00);
            pay.push_back(8'h07);
          end
          CmdVdm: begin
            pay.push_back(8'hff);
            pay.push_back(8'h00);
            pay.push_back(8'h19);
            pay.push_back(8'he5);
            pay.push_back(8'h00);
            pay.push_back(8'h00);
          end
          default: return 0;
        endcase
        frame.push_back({rq_addr, 1'b0});
        frame.push_back(SmbusCmdMctp);
        frame.push_back(8'(8 + pay.size()));
        frame.push_back({own_addr, 1'b1});
        frame.push_back(HdrVersion);
        frame.push_back(rq_eid);
        frame.push_back(ep_eid);
        frame.push_back(TagFlags | {5'd0, rq_tag});
        frame.push_back(8'h00);
        frame.push_back({3'd0, rq_inst});
        frame.push_back(rq_cmd);
        foreach (pay[j]) frame.push_back(pay[j]);
        pec = '0;
        foreach (frame[j]) pec = pec_step(pec, frame[j]);
        frame.push_back(pec);
        n = frame.size();
        for (i = 0; i < n; i++) begin
          bt.data  = frame[i];
          bt.first = (i == 0);
          bt.last  = (i == n - 1);
          reply_q.push_back(bt);
        end
        return n;
      end
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endtask

  // checker, predictor feed and watchdog
  always @(posedge clk_i) begin
    beat_t want;
    int    n;
    int    row_beats;
    if (rst_ni) begin
      if (cfg_we_i) own_addr = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch("beat with none pending", 8'h00, tx_byte_o);
        end else begin
          want = reply_q.pop_front();
          if (tx_byte_o !== want.data) report_mismatch("tx_byte", want.data, tx_byte_o);
          if (is_address_o !== want.first)
            report_mismatch("is_address", want.first, is_address_o);
          if (last_o !== want.last) report_mismatch("last", want.last, last_o);
          if (want.last) replies_seen++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        events_seen++;
        n = respond_to_event(kind_i, data_byte_i);
        if (row_beat_q.size() != 0) begin
          row_beats = row_beat_q.pop_front();
          if (row_beats >= 0 && row_beats != n)
            report_mismatch("script reply length", 8'(row_beats), 8'(n));
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb: no beat moved for %0d cycles", IdleLimit);
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  // reply side: a fresh stall length per beat, one long hold on request
  initial begin
    int n;
    forever begin
      n = hold_req ? LongHold : (calm ? 0 : $urandom_range(0, 18));
      hold_req = 1'b0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic put_item(input logic [1:0] k, input logic [7:0] d, input bit tally);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    if (tally) items_sent++;
  endtask

  // drop valid, wait out every pending reply, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_own_address(input logic [6:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_request_body(input int nbytes);
    int         i;
    logic [7:0] b;
    for (i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if (i == 7) b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : MsgTypeControl;
      if (i == 9) b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
      put_item(KIND_BYTE, b, 1'b1);
    end
  endtask

  task automatic send_request();
    int r;
    int i;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      put_item(KIND_START, 8'($urandom), 1'b1);
      send_request_body(($urandom_range(0, 3) == 0) ? 12 + $urandom_range(1, 3) : 12);
      put_item(KIND_FINISH, 8'($urandom), 1'b1);
    end else if (r < 82) begin
      // cut short: finish or restart before the request body is complete
      put_item(KIND_START, 8'($urandom), 1'b1);
      send_request_body($urandom_range(0, 11));
      put_item($urandom_range(0, 1) ? KIND_FINISH : KIND_START, 8'($urandom), 1'b1);
    end else if (r < 90) begin
      put_item(KIND_FINISH, 8'($urandom), 1'b1);
    end else begin
      for (i = 0; i < $urandom_range(1, 3); i++)
        put_item(2'($urandom_range(0, 3)), 8'($urandom), 1'b1);
    end
  endtask

  // runs the byte position into its ceiling; the tail must not be captured
  task automatic send_long_request();
    int i;
    put_item(KIND_START, 8'($urandom), 1'b1);
    send_request_body(12);
    for (i = 0; i < 260; i++) put_item(KIND_BYTE, 8'($urandom), 1'b0);
    put_item(KIND_FINISH, 8'($urandom), 1'b1);
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_own_address(7'h7f);
    calm = 1'b1;
    for (k = 0; k < ScriptLen; k++) begin
      row_beat_q.push_back(Script[k].beats);
      put_item(Script[k].kind, Script[k].data, 1'b1);
    end
    settle();

    write_own_address(7'h00);
    calm     = 1'b0;
    hold_req = 1'b1;
    while (items_sent < 110) send_request();
    settle();

    write_own_address(7'($urandom_range(1, 126)));
    calm = 1'b1;
    while (items_sent < 160) send_request();
    settle();

    write_own_address(7'($urandom));
    calm = 1'b0;
    send_long_request();
    while (items_sent < 200) send_request();
    settle();
    while (items_sent < 250) send_request();
    settle();
    repeat (20) @(posedge clk_i);

    if (reply_q.size() != 0) mismatches += reply_q.size();
    $display("tb: %0d bus events taken, %0d replies in %0d beats compared, %0d mismatches",
             events_seen, replies_seen, beats_seen, mismatches);
    $display("tb: four own-address settings, a long reply-side hold, one over-long request");
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mctp_ce_pkg.sv
rtl/mctp_smbus_control_endpoint_top.sv
verif/tb.sv
